// ----- rtl/core/shamh_pkg.sv -----
// shared types and constants of the sha-256 message hasher
`timescale 1ns / 1ps

package shamh_pkg;

    typedef logic [31:0] t_word;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS          = 64;
    localparam int DIGEST_WORDS    = 8;
    localparam int LEN_BITS        = 61;
    localparam int WORD_BYTES      = 4;

    // word slot where the two length words start (byte 56 of the block)
    localparam logic [3:0] LEN_HI_SLOT = 4'(56 / WORD_BYTES);
    localparam logic [3:0] LEN_LO_SLOT = 4'(56 / WORD_BYTES + 1);

    // marker byte placed after the last message byte
    localparam logic [7:0] PAD_MARKER  = 8'h80;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // rotate right by a fixed amount
    function automatic t_word ror(input t_word x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/core/sha256_message_hasher_core.sv -----
// sha-256 message hasher: block packing, padding, compression and digest output
`timescale 1ns / 1ps

// Message words enter big-endian, one item per cycle while o_stall is low. Each
// sixteenth word starts a compression of the block, with the input stalled: the
// states S_PRE0 and S_PRE1 prime the schedule memory, the rounds run on the
// single round unit and S_ADD folds the result into the chain value. The pace
// is set by the one round unit and the two read ports of the 16-word schedule
// memory. A final item is followed by one padding word per remaining word slot
// (up to 15, or up to 18 with a second closing block), one or two compressions,
// and eight digest items, high word first, which wait on i_stall. Afterwards the
// block is back in its initial state and takes the next message.

module sha256_message_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_word,
    // digest items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_PRE0 = 3'd2;
    localparam logic [2:0] S_PRE1 = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_wib;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic [shamh_pkg::LEN_BITS-1:0] r_bytes;
    logic        r_final;
    logic        r_pend_mark;
    logic        r_len_hi;
    logic        r_len_done;

    shamh_pkg::t_word r_chain [shamh_pkg::DIGEST_WORDS];
    shamh_pkg::t_word r_s     [shamh_pkg::DIGEST_WORDS];
    shamh_pkg::t_word n_s     [shamh_pkg::DIGEST_WORDS];
    shamh_pkg::t_word r_prev;
    shamh_pkg::t_word r_w1;
    shamh_pkg::t_word r_w2;

    logic             ram_we;
    logic [3:0]       ram_waddr;
    shamh_pkg::t_word ram_wdata;
    logic [3:0]       ram_raddr_a;
    logic [3:0]       ram_raddr_b;
    shamh_pkg::t_word ram_rdata_a;
    shamh_pkg::t_word ram_rdata_b;

    logic             in_acc;
    logic             out_acc;
    logic [2:0]       nbytes;
    shamh_pkg::t_word pad_first;
    shamh_pkg::t_word pad_seq;
    shamh_pkg::t_word wi;
    shamh_pkg::t_word t1;
    shamh_pkg::t_word t2;

    assign o_stall = (r_state != S_FILL);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign o_digest_word  = r_chain[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 3'(shamh_pkg::DIGEST_WORDS - 1));

    // byte count of the item, clamped to a full word
    assign nbytes = (i_valid_bytes > 3'(shamh_pkg::WORD_BYTES)) ?
                    3'(shamh_pkg::WORD_BYTES) : i_valid_bytes;

    // final word with fewer than four bytes: keep valid bytes, add the marker
    always_comb begin
        case (nbytes)
            3'd0:    pad_first = {shamh_pkg::PAD_MARKER, 24'h0};
            3'd1:    pad_first = {i_message_word[31:24], shamh_pkg::PAD_MARKER, 16'h0};
            3'd2:    pad_first = {i_message_word[31:16], shamh_pkg::PAD_MARKER, 8'h0};
            3'd3:    pad_first = {i_message_word[31:8], shamh_pkg::PAD_MARKER};
            default: pad_first = i_message_word;
        endcase
    end

    // padding words: marker, zero fill, then the bit length
    always_comb begin
        if (r_pend_mark) begin
            pad_seq = {shamh_pkg::PAD_MARKER, 24'h0};
        end else if (r_wib == shamh_pkg::LEN_HI_SLOT) begin
            pad_seq = r_bytes[60:29];
        end else if (r_wib == shamh_pkg::LEN_LO_SLOT && r_len_hi) begin
            pad_seq = {r_bytes[28:0], 3'b000};
        end else begin
            pad_seq = '0;
        end
    end

    // schedule word: stored word in the first sixteen rounds, expanded after
    assign wi = (r_rnd[5:4] == 2'b00) ? r_prev :
                r_prev + shamh_pkg::small_sigma0(ram_rdata_a) + ram_rdata_b
                + shamh_pkg::small_sigma1(r_w2);

    // one compression round
    always_comb begin
        t1 = r_s[7] + shamh_pkg::big_sigma1(r_s[4])
             + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
             + shamh_pkg::ROUND_K[r_rnd] + wi;
        t2 = shamh_pkg::big_sigma0(r_s[0])
             + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
        n_s[0] = t1 + t2;
        n_s[1] = r_s[0];
        n_s[2] = r_s[1];
        n_s[3] = r_s[2];
        n_s[4] = r_s[3] + t1;
        n_s[5] = r_s[4];
        n_s[6] = r_s[5];
        n_s[7] = r_s[6];
    end

    // schedule memory ports
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_wib;
        ram_wdata   = '0;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        unique case (r_state)
            S_FILL: begin
                ram_we    = in_acc;
                ram_wdata = (!i_final_word || nbytes == 3'(shamh_pkg::WORD_BYTES)) ?
                            i_message_word : pad_first;
            end
            S_PAD: begin
                ram_we    = 1'b1;
                ram_wdata = pad_seq;
            end
            S_PRE0: begin
                ram_raddr_a = 4'd0;
            end
            S_PRE1: begin
                ram_raddr_a = 4'd1;
            end
            S_RND: begin
                ram_we      = (r_rnd[5:4] != 2'b00);
                ram_waddr   = r_rnd[3:0];
                ram_wdata   = wi;
                ram_raddr_a = r_rnd[3:0] + 4'd2;
                ram_raddr_b = r_rnd[3:0] + 4'd10;
            end
            default: begin
            end
        endcase
    end

    shamh_ram #(
        .WIDTH (32),
        .DEPTH (shamh_pkg::WORDS_PER_BLOCK)
    ) u_sched (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                if (in_acc) begin
                    if (r_wib == 4'hf) begin
                        n_state = S_PRE0;
                    end else if (i_final_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_wib == 4'hf) begin
                    n_state = S_PRE0;
                end
            end
            S_PRE0: n_state = S_PRE1;
            S_PRE1: n_state = S_RND;
            S_RND: begin
                if (r_rnd == 6'(shamh_pkg::ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!r_final) begin
                    n_state = S_FILL;
                end else if (r_len_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_acc && o_digest_last) begin
                    n_state = S_FILL;
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_wib       <= '0;
            r_rnd       <= '0;
            r_oidx      <= '0;
            r_bytes     <= '0;
            r_final     <= 1'b0;
            r_pend_mark <= 1'b0;
            r_len_hi    <= 1'b0;
            r_len_done  <= 1'b0;
            for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
                r_chain[i] <= shamh_pkg::INIT_HASH[i];
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_FILL && in_acc) begin
                r_wib <= r_wib + 4'd1;
                if (i_final_word) begin
                    r_bytes     <= r_bytes + shamh_pkg::LEN_BITS'(nbytes);
                    r_final     <= 1'b1;
                    r_pend_mark <= (nbytes == 3'(shamh_pkg::WORD_BYTES));
                end else begin
                    r_bytes <= r_bytes + shamh_pkg::LEN_BITS'(shamh_pkg::WORD_BYTES);
                end
            end
            if (r_state == S_PAD) begin
                r_wib <= r_wib + 4'd1;
                if (r_pend_mark) begin
                    r_pend_mark <= 1'b0;
                end else if (r_wib == shamh_pkg::LEN_HI_SLOT) begin
                    r_len_hi <= 1'b1;
                end else if (r_wib == shamh_pkg::LEN_LO_SLOT && r_len_hi) begin
                    r_len_done <= 1'b1;
                end
            end
            if (r_state == S_PRE1) begin
                r_rnd <= '0;
            end else if (r_state == S_RND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            // fold the working variables into the chain value
            if (r_state == S_ADD) begin
                for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_s[i];
                end
            end
            // digest items, then back to the initial state
            if (out_acc) begin
                r_oidx <= r_oidx + 3'd1;
                if (o_digest_last) begin
                    r_bytes    <= '0;
                    r_final    <= 1'b0;
                    r_len_hi   <= 1'b0;
                    r_len_done <= 1'b0;
                    for (int i = 0; i < shamh_pkg::DIGEST_WORDS; i++) begin
                        r_chain[i] <= shamh_pkg::INIT_HASH[i];
                    end
                end
            end
        end
    end

    // working variables and schedule taps
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRE0) begin
            r_s <= r_chain;
        end else if (r_state == S_RND) begin
            r_s <= n_s;
        end
        if (r_state == S_PRE1 || r_state == S_RND) begin
            r_prev <= ram_rdata_a;
        end
        if (r_state == S_RND) begin
            r_w1 <= wi;
            r_w2 <= r_w1;
        end
    end

    // no item enters while digest items are on offer
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !in_acc)
        else $error("message item accepted while digest is on offer");

    // rounds start from zero after the schedule memory is primed
    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE1) |=> (r_state == S_RND && r_rnd == 6'd0))
        else $error("round counter not cleared at start of compression");

    // the last digest item leaves the block in its initial state
    a_reset_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_digest_last) |=>
        (r_state == S_FILL && r_bytes == '0 && r_wib == 4'd0 && !r_final))
        else $error("state not restored after last digest item");

    // padding only runs inside a final sequence
    a_pad_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_final && !r_len_done))
        else $error("padding outside a final sequence");

endmodule

// ----- rtl/core/shamh_ram.sv -----
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module shamh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the sha-256 message hasher core
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_COUNT   = 170;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;

    // own copy of the round constants and initial hash value
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        MODE_RX_HEAVY,
        MODE_TX_HEAVY,
        MODE_NO_IDLE
    } t_idle_mode;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        fin;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_message_word;
    logic [2:0]  i_valid_bytes;
    logic        i_final_word;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;

    // hasher state kept by the testbench
    logic [31:0] chain_val [8];
    logic [31:0] block_words [16];
    logic [3:0]  block_fill;
    logic [60:0] byte_total;

    t_msg_item    message_items_q [$];
    t_digest_item pending_digests [$];
    t_msg_item    offer_item;
    t_digest_item digest_due;

    t_idle_mode idle_mode;
    int         total_items;
    int         words_taken;
    int         fault_cnt;
    int         quiet_cycles;
    int         hold_cycles_left;
    bit         hold_request;
    bit         word_taken;

    sha256_message_hasher_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_final_word   (i_final_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit roll_pct(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic clear_hash_state();
        for (int i = 0; i < 8; i++) chain_val[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        block_fill = '0;
        byte_total = '0;
    endtask

    // 64 rounds over the full block, folded into the chain value
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] s [8];
        logic [31:0] wi, x15, x2, t1, t2, ch, mj;
        for (int i = 0; i < 16; i++) w[i] = block_words[i];
        for (int i = 0; i < 8; i++) s[i] = chain_val[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wi = w[r];
            end else begin
                x15 = w[(r - 15) & 15];
                x2  = w[(r - 2) & 15];
                wi  = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                    + w[(r - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[r & 15] = wi;
            end
            ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
            mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25)) + ch
               + SHA_K[r] + wi;
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22)) + mj;
            s[7] = s[6];
            s[6] = s[5];
            s[5] = s[4];
            s[4] = s[3] + t1;
            s[3] = s[2];
            s[2] = s[1];
            s[1] = s[0];
            s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_val[i] = chain_val[i] + s[i];
    endtask

    task automatic append_block_word(input logic [31:0] v);
        block_words[block_fill] = v;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0) compress_block();
    endtask

    // absorb one message item; a final item closes the message and yields the digest
    task automatic hash_message_word(input logic [31:0] word, input logic [2:0] nbytes,
                                     input logic fin);
        int           nb;
        logic [31:0]  keep;
        logic [31:0]  pad;
        logic [63:0]  bit_len;
        t_digest_item d;
        if (!fin) begin
            byte_total = byte_total + 61'd4;
            append_block_word(word);
        end else begin
            nb = (nbytes > 3'd4) ? 4 : int'(nbytes);
            byte_total = byte_total + 61'(nb);
            if (nb == 4) begin
                append_block_word(word);
                pad = 32'h8000_0000;
            end else begin
                keep = (nb == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * nb));
                pad  = (word & keep) | (32'h8000_0000 >> (8 * nb));
            end
            append_block_word(pad);
            // zero fill up to the two length words
            while (block_fill != 4'd14) append_block_word(32'h0);
            bit_len = {byte_total, 3'b000};
            append_block_word(bit_len[63:32]);
            append_block_word(bit_len[31:0]);
            for (int i = 0; i < 8; i++) begin
                d.word  = chain_val[i];
                d.index = 3'(i);
                d.last  = (i == 7);
                pending_digests.insert(pending_digests.size(), d);
            end
            clear_hash_state();
        end
    endtask

    task automatic add_item(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic fin);
        t_msg_item it;
        it.word   = word;
        it.nbytes = nbytes;
        it.fin    = fin;
        message_items_q.insert(message_items_q.size(), it);
    endtask

    // sender: presents the next item at the falling edge, holds it while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (message_items_q.size() != 0 && !roll_pct(idle_mode == MODE_RX_HEAVY ? 32 :
                                                          idle_mode == MODE_TX_HEAVY ? 85 : 0)) begin
                offer_item = message_items_q.pop_front();
                i_valid        <= 1'b1;
                i_message_word <= offer_item.word;
                i_valid_bytes  <= offer_item.nbytes;
                i_final_word   <= offer_item.fin;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // accepted message items feed the prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            hash_message_word(i_message_word, i_valid_bytes, i_final_word);
            words_taken = words_taken + 1;
            word_taken  = 1'b1;
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles_left > 0) begin
            hold_cycles_left = hold_cycles_left - 1;
            i_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request     = 1'b0;
            hold_cycles_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= roll_pct(idle_mode == MODE_RX_HEAVY ? 85 :
                                idle_mode == MODE_TX_HEAVY ? 32 : 0);
        end
    end

    // digest checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digests.size() == 0) begin
                fault_cnt = fault_cnt + 1;
                if (fault_cnt <= REPORT_MAX)
                    $display("unexpected digest item: word %h index %0d last %0b",
                             o_digest_word, o_digest_index, o_digest_last);
            end else begin
                digest_due = pending_digests.pop_front();
                if (o_digest_word !== digest_due.word || o_digest_index !== digest_due.index ||
                    o_digest_last !== digest_due.last) begin
                    fault_cnt = fault_cnt + 1;
                    if (fault_cnt <= REPORT_MAX)
                        $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 digest_due.word, digest_due.index, digest_due.last,
                                 o_digest_word, o_digest_index, o_digest_last);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("** sha256_message_hasher_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int       msg_len;
        int       roll;
        logic [2:0] nb;

        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_message_word   = '0;
        i_valid_bytes    = '0;
        i_final_word     = 1'b0;
        idle_mode        = MODE_RX_HEAVY;
        words_taken      = 0;
        fault_cnt        = 0;
        quiet_cycles     = 0;
        hold_cycles_left = 0;
        hold_request     = 1'b0;
        word_taken       = 1'b0;
        clear_hash_state();

        // empty message, bytes of the final word all ignored
        add_item(32'hffff_ffff, 3'd0, 1'b1);
        // "abc" with a stray low byte that must be dropped
        add_item(32'h6162_63ff, 3'd3, 1'b1);
        // one-word messages over the final byte counts, above four clipped to four
        add_item(32'ha5a5_a5a5, 3'd1, 1'b1);
        add_item(32'hffff_ffff, 3'd2, 1'b1);
        add_item(32'hffff_ffff, 3'd4, 1'b1);
        add_item(32'h0000_0000, 3'd7, 1'b1);
        add_item(32'h8000_0001, 3'd5, 1'b1);
        // fifteen words: odd byte counts on non-final words, padding spills to a second block
        for (int k = 0; k < 14; k++)
            add_item((k % 3 == 0) ? 32'h0 : (k % 3 == 1) ? 32'hffff_ffff : $urandom(),
                     3'(k % 8), 1'b0);
        add_item($urandom(), 3'd6, 1'b1);

        // random messages, mostly short, a few spanning several blocks
        while (message_items_q.size() < ITEM_COUNT) begin
            roll = $urandom_range(0, 99);
            msg_len = (roll < 75) ? $urandom_range(1, 20) :
                      (roll < 93) ? $urandom_range(21, 40) : $urandom_range(41, 64);
            // trim the last message to the item budget
            if (msg_len > ITEM_COUNT - message_items_q.size())
                msg_len = ITEM_COUNT - message_items_q.size();
            for (int k = 0; k < msg_len - 1; k++) begin
                nb = roll_pct(85) ? 3'd4 : 3'($urandom_range(0, 7));
                add_item($urandom(), nb, 1'b0);
            end
            add_item($urandom(), 3'($urandom_range(0, 7)), 1'b1);
        end
        total_items = message_items_q.size();

        // hold reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idling phases, then a long receiver hold-off with the sender at full rate
        while (words_taken < total_items / 3) @(posedge i_clk);
        idle_mode = MODE_TX_HEAVY;
        while (words_taken < (2 * total_items) / 3) @(posedge i_clk);
        idle_mode    = MODE_NO_IDLE;
        hold_request = 1'b1;

        // drain
        while (words_taken < total_items) @(posedge i_clk);
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_digests.size() != 0) begin
            fault_cnt = fault_cnt + 1;
            $display("%0d digest items never arrived", pending_digests.size());
        end
        if (fault_cnt == 0) begin
            $display("** sha256_message_hasher_core: PASSED **");
        end else begin
            $display("** sha256_message_hasher_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sha256_message_hasher_core.f -----
rtl/core/shamh_pkg.sv
rtl/core/shamh_ram.sv
rtl/core/sha256_message_hasher_core.sv
tb/testbench.sv
